[rtl/wolff_cluster_flip_engine_defines.svh]
// ---------------------------------------------------------------------------
// Wolff cluster flip engine: assertion macros
// Shared property shorthands for the clocked checks in the RTL.
// ---------------------------------------------------------------------------
`ifndef WOLFF_CLUSTER_FLIP_ENGINE_DEFINES_SVH
`define WOLFF_CLUSTER_FLIP_ENGINE_DEFINES_SVH

// same-cycle implication, disabled in reset
`define WCF_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wcf check failed");

// next-cycle implication, disabled in reset
`define WCF_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wcf check failed");

`endif

[rtl/wcf_pkg.sv]
// ---------------------------------------------------------------------------
// wcf_pkg
// Lattice geometry, request codes, command/status structs, helper functions.
// ---------------------------------------------------------------------------
`default_nettype none

package wcf_pkg;

  localparam int SIDE_BITS = 7;
  localparam int SIDE      = 1 << SIDE_BITS;
  localparam int SITE_BITS = 2 * SIDE_BITS;
  localparam int NSITES    = 1 << SITE_BITS;
  localparam int SP_BITS   = SITE_BITS + 1;
  localparam int CNT_BITS  = 15;
  localparam int MAG_BITS  = 16;
  localparam int ENT_BITS  = SITE_BITS + 2;

  localparam logic [1:0] REQ_WRITE  = 2'd0;
  localparam logic [1:0] REQ_READ   = 2'd1;
  localparam logic [1:0] REQ_UPDATE = 2'd2;

  localparam logic [1:0] DIR_UP     = 2'd0;
  localparam logic [1:0] DIR_DOWN   = 2'd1;
  localparam logic [1:0] DIR_LEFT   = 2'd2;
  localparam logic [1:0] DIR_RIGHT  = 2'd3;

  localparam logic       CFG_THRESHOLD = 1'b0;
  localparam logic       CFG_SEED      = 1'b1;

  localparam logic [31:0] THR_RESET = 32'd1380000000;
  localparam logic [31:0] RNG_RESET = 32'd1;
  localparam logic signed [MAG_BITS-1:0] SUM_RESET = MAG_BITS'(NSITES);

  typedef struct packed {
    logic clr_wr;     // clearing pass write
    logic in_load;    // latch accepted word
    logic req_fin;    // finish read/write/unused request
    logic seed_draw;  // step generator, read seed spin
    logic seed_flip;  // flip seed, push it
    logic top_proc;   // advance top entry, read neighbor spin
    logic nb_proc;    // test neighbor, maybe join and push
    logic upd_fin;    // finish update
  } cmd_t;

  typedef struct packed {
    logic       clr_done;
    logic       sp_zero;
    logic       out_busy;
  } sts_t;

  function automatic logic [31:0] xs32(input logic [31:0] x);
    logic [31:0] a;
    logic [31:0] b;
    a = x ^ (x << 13);
    b = a ^ (a >> 17);
    return b ^ (b << 5);
  endfunction

  function automatic logic [SITE_BITS-1:0] neighbor(input logic [SITE_BITS-1:0] s,
                                                    input logic [1:0] dir);
    logic [SIDE_BITS-1:0] row;
    logic [SIDE_BITS-1:0] col;
    row = s[SITE_BITS-1:SIDE_BITS];
    col = s[SIDE_BITS-1:0];
    unique case (dir)
      DIR_UP:   row = row - 1'b1;
      DIR_DOWN: row = row + 1'b1;
      DIR_LEFT: col = col - 1'b1;
      default:  col = col + 1'b1;
    endcase
    return {row, col};
  endfunction

endpackage

`default_nettype wire

[rtl/wcf_if.sv]
// ---------------------------------------------------------------------------
// wcf channel interfaces
// Request and result channels with valid/ready handshake.
// ---------------------------------------------------------------------------
`default_nettype none

interface wcf_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    req_type;
  logic [wcf_pkg::SITE_BITS-1:0] site;
  logic                          spin_value;
  modport source (output valid, req_type, site, spin_value, input ready);
  modport sink   (input valid, req_type, site, spin_value, output ready);
endinterface

interface wcf_out_if;
  logic                                valid;
  logic                                ready;
  logic                                read_spin;
  logic [wcf_pkg::CNT_BITS-1:0]        cluster_size;
  logic signed [wcf_pkg::MAG_BITS-1:0] magnetization;
  modport source (output valid, read_spin, cluster_size, magnetization, input ready);
  modport sink   (input valid, read_spin, cluster_size, magnetization, output ready);
endinterface

`default_nettype wire

[rtl/wcf_ctrl.sv]
// ---------------------------------------------------------------------------
// wcf_ctrl
// Sequencer: clearing pass, request dispatch, cluster walk steps.
// ---------------------------------------------------------------------------
`default_nettype none

module wcf_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic [1:0]    in_req,
  input  wire wcf_pkg::sts_t sts,
  output wcf_pkg::cmd_t      cmd
);

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_REQ, S_DRAW, S_SEED, S_POP, S_TOP, S_NB
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_ready = (state_r == S_IDLE) && !sts.out_busy;
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          cmd.in_load = 1'b1;
          state_nxt   = (in_req == wcf_pkg::REQ_UPDATE) ? S_DRAW : S_REQ;
        end
      end
      S_REQ: begin
        cmd.req_fin = 1'b1;
        state_nxt   = S_IDLE;
      end
      S_DRAW: begin
        cmd.seed_draw = 1'b1;
        state_nxt     = S_SEED;
      end
      S_SEED: begin
        cmd.seed_flip = 1'b1;
        state_nxt     = S_POP;
      end
      S_POP: begin
        if (sts.sp_zero) begin
          cmd.upd_fin = 1'b1;
          state_nxt   = S_IDLE;
        end else begin
          state_nxt = S_TOP;
        end
      end
      S_TOP: begin
        cmd.top_proc = 1'b1;
        state_nxt    = S_NB;
      end
      default: begin
        cmd.nb_proc = 1'b1;
        state_nxt   = S_POP;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/wcf_dp.sv]
// ---------------------------------------------------------------------------
// wcf_dp
// Spin and stack memories, generator, sums, result register.
// ---------------------------------------------------------------------------
`default_nettype none

`include "wolff_cluster_flip_engine_defines.svh"

module wcf_dp (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire wcf_pkg::cmd_t                        cmd,
  output wcf_pkg::sts_t                             sts,
  input  wire logic [1:0]                           in_req,
  input  wire logic [wcf_pkg::SITE_BITS-1:0]        in_site,
  input  wire logic                                 in_val,
  input  wire logic                                 cfg_we,
  input  wire logic                                 cfg_index,
  input  wire logic [31:0]                          cfg_data,
  output logic                                      out_valid,
  input  wire logic                                 out_ready,
  output logic                                      out_read_spin,
  output logic [wcf_pkg::CNT_BITS-1:0]              out_size,
  output logic signed [wcf_pkg::MAG_BITS-1:0]       out_mag
);

  logic                          spin_mem [wcf_pkg::NSITES];
  logic [wcf_pkg::ENT_BITS-1:0]  stk_mem  [wcf_pkg::NSITES];

  logic [wcf_pkg::SITE_BITS-1:0] clr_addr_r;
  logic [1:0]                    req_r;
  logic [wcf_pkg::SITE_BITS-1:0] site_r;
  logic                          val_r;
  logic [31:0]                   thr_r;
  logic [31:0]                   rng_r, rng_nxt;
  logic signed [wcf_pkg::MAG_BITS-1:0] sum_r, sum_nxt;
  logic [wcf_pkg::SP_BITS-1:0]   sp_r;
  logic [wcf_pkg::CNT_BITS-1:0]  cnt_r;
  logic                          sign_r;
  logic [wcf_pkg::SITE_BITS-1:0] seed_r;
  logic [wcf_pkg::SITE_BITS-1:0] nb_r;
  logic                          spin_rd_r;
  logic [wcf_pkg::ENT_BITS-1:0]  stk_rd_r;
  logic                          out_valid_r;

  logic          spin_we, spin_wd, flip_en, match, join_en, push_en;
  logic [wcf_pkg::SITE_BITS-1:0] spin_wa, spin_ra, stk_ra, stk_wa, top_site, nb_site;
  logic          stk_we;
  logic [wcf_pkg::ENT_BITS-1:0] stk_wd;
  logic [1:0]    top_dir;
  logic [wcf_pkg::SP_BITS-1:0] sp_dec;

  assign rng_nxt  = wcf_pkg::xs32(rng_r);
  assign top_site = stk_rd_r[wcf_pkg::ENT_BITS-1:2];
  assign top_dir  = stk_rd_r[1:0];
  assign nb_site  = wcf_pkg::neighbor(top_site, top_dir);
  assign sp_dec   = sp_r - 1'b1;
  assign stk_ra   = sp_dec[wcf_pkg::SITE_BITS-1:0];
  assign match    = (spin_rd_r == sign_r);
  assign join_en  = cmd.nb_proc && match && (rng_nxt < thr_r);
  assign push_en  = join_en && !sp_r[wcf_pkg::SP_BITS-1];

  // any real spin flip (the clearing pass writes without flipping)
  assign flip_en = (cmd.req_fin && req_r == wcf_pkg::REQ_WRITE && spin_rd_r != val_r)
                 || cmd.seed_flip || join_en;

  always_comb begin
    sum_nxt = sum_r;
    if (flip_en) sum_nxt = spin_rd_r ? sum_r - 16'sd2 : sum_r + 16'sd2;
  end

  always_comb begin
    spin_we = cmd.clr_wr || flip_en;
    spin_wd = cmd.clr_wr ? 1'b1 : ~spin_rd_r;
    priority if (cmd.clr_wr)    spin_wa = clr_addr_r;
    else if (cmd.seed_flip)     spin_wa = seed_r;
    else if (cmd.nb_proc)       spin_wa = nb_r;
    else                        spin_wa = site_r;
  end

  always_comb begin
    priority if (cmd.seed_draw) spin_ra = rng_nxt[wcf_pkg::SITE_BITS-1:0];
    else if (cmd.top_proc)      spin_ra = nb_site;
    else                        spin_ra = in_site;
  end

  always_comb begin
    stk_we = cmd.seed_flip || (cmd.top_proc && top_dir != wcf_pkg::DIR_RIGHT) || push_en;
    priority if (cmd.seed_flip) begin
      stk_wa = '0;
      stk_wd = {seed_r, wcf_pkg::DIR_UP};
    end else if (cmd.top_proc) begin
      stk_wa = stk_ra;
      stk_wd = stk_rd_r + 1'b1;
    end else begin
      stk_wa = sp_r[wcf_pkg::SITE_BITS-1:0];
      stk_wd = {nb_r, wcf_pkg::DIR_UP};
    end
  end

  always_ff @(posedge clk) begin
    if (spin_we) spin_mem[spin_wa] <= spin_wd;
    spin_rd_r <= spin_mem[spin_ra];
  end

  always_ff @(posedge clk) begin
    if (stk_we) stk_mem[stk_wa] <= stk_wd;
    stk_rd_r <= stk_mem[stk_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r  <= '0;
      thr_r       <= wcf_pkg::THR_RESET;
      rng_r       <= wcf_pkg::RNG_RESET;
      sum_r       <= wcf_pkg::SUM_RESET;
      sp_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clr_wr) clr_addr_r <= clr_addr_r + 1'b1;
      sum_r <= sum_nxt;
      if (cfg_we && cfg_index == wcf_pkg::CFG_THRESHOLD) thr_r <= cfg_data;
      if (cfg_we && cfg_index == wcf_pkg::CFG_SEED) begin
        rng_r <= (cfg_data == '0) ? wcf_pkg::RNG_RESET : cfg_data;
      end else if (cmd.seed_draw || cmd.nb_proc && match) begin
        rng_r <= rng_nxt;
      end
      if (cmd.seed_flip)                                      sp_r <= wcf_pkg::SP_BITS'(1);
      else if (cmd.top_proc && top_dir == wcf_pkg::DIR_RIGHT) sp_r <= sp_dec;
      else if (push_en)                                       sp_r <= sp_r + 1'b1;
      if (cmd.req_fin || cmd.upd_fin) out_valid_r <= 1'b1;
      else if (out_ready)             out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      req_r  <= in_req;
      site_r <= in_site;
      val_r  <= in_val;
    end
    if (cmd.seed_draw) seed_r <= rng_nxt[wcf_pkg::SITE_BITS-1:0];
    if (cmd.top_proc)  nb_r   <= nb_site;
    if (cmd.seed_flip) begin
      sign_r <= spin_rd_r;
      cnt_r  <= wcf_pkg::CNT_BITS'(1);
    end else if (join_en) begin
      cnt_r <= cnt_r + 1'b1;
    end
    if (cmd.req_fin) begin
      out_read_spin <= (req_r == wcf_pkg::REQ_READ) ? spin_rd_r : 1'b0;
      out_size      <= '0;
      out_mag       <= sum_nxt;
    end else if (cmd.upd_fin) begin
      out_read_spin <= 1'b0;
      out_size      <= cnt_r;
      out_mag       <= sum_r;
    end
  end

  assign out_valid = out_valid_r;
  assign sts       = '{clr_done: (clr_addr_r == '1),
                       sp_zero:  (sp_r == '0),
                       out_busy: out_valid_r};

  `WCF_ASSERT_IMPL(a_sp_bound, 1'b1, sp_r <= wcf_pkg::SP_BITS'(wcf_pkg::NSITES))
  `WCF_ASSERT_NEXT(a_fin_valid, cmd.req_fin || cmd.upd_fin, out_valid_r)
  `WCF_ASSERT_IMPL(a_upd_count, cmd.upd_fin, cnt_r != '0)
  `WCF_ASSERT_IMPL(a_clear_quiet, cmd.clr_wr, !out_valid_r && sp_r == '0)

endmodule

`default_nettype wire

[rtl/wolff_cluster_flip_engine.sv]
// ---------------------------------------------------------------------------
// wolff_cluster_flip_engine
// Wolff cluster updates on a periodic 128x128 one-bit spin lattice.
// ---------------------------------------------------------------------------
//  channel | dir | handshake     | word
//  in_if   | in  | valid/ready   | req_type, site, spin_value
//  out_if  | out | valid/ready   | read_spin, cluster_size, magnetization
//  cfg_*   | in  | cfg_we only   | cfg_index, cfg_data (32b)
//
//  After reset a clearing pass sets all 16384 spins to +1, with in_if.ready
//  low throughout. Config writes are taken during it.
//  Read/write/unused requests: accept and finish steps, then the result word is held.
//  Update: the seed takes accept, draw and flip steps; each neighbor examined
//  (four per cluster site) takes pop, top and neighbor steps, and a final pop
//  step finishes, paced by the registered spin and stack memory reads.
//  One request at a time: ready stays low until the result word is taken.
// ---------------------------------------------------------------------------
`default_nettype none

module wolff_cluster_flip_engine (
  input  wire logic        clk,
  input  wire logic        rst_n,
  wcf_in_if.sink           in_if,
  wcf_out_if.source        out_if,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data
);

  wcf_pkg::cmd_t cmd;
  wcf_pkg::sts_t sts;

  // sequencer: owns the input handshake
  wcf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .in_req   (in_if.req_type),
    .sts      (sts),
    .cmd      (cmd)
  );

  // storage, generator and result register
  wcf_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_req        (in_if.req_type),
    .in_site       (in_if.site),
    .in_val        (in_if.spin_value),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .out_valid     (out_if.valid),
    .out_ready     (out_if.ready),
    .out_read_spin (out_if.read_spin),
    .out_size      (out_if.cluster_size),
    .out_mag       (out_if.magnetization)
  );

endmodule

`default_nettype wire

[tb/tb.sv]
// ---------------------------------------------------------------------------
// tb: testbench for wolff_cluster_flip_engine
// Drives write, read, update and unused requests through the request channel.
// Every accepted word goes through a local lattice model, which predicts the
// result word. Threshold and seed are changed between phases, with both
// channels idle, and include their extremes.
// ---------------------------------------------------------------------------
`default_nettype none

module tb;

  localparam int WATCHDOG_LIMIT = 1000000;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]                    req_type;
    logic [wcf_pkg::SITE_BITS-1:0] site;
    logic                          spin_value;
  } spin_req_t;

  typedef struct packed {
    logic                                read_spin;
    logic [wcf_pkg::CNT_BITS-1:0]        cluster_size;
    logic signed [wcf_pkg::MAG_BITS-1:0] magnetization;
  } spin_res_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic cfg_index;
  logic [31:0] cfg_data;

  wcf_in_if  in_if ();
  wcf_out_if out_if ();

  wolff_cluster_flip_engine dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_if),
    .out_if   (out_if),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // pending request words and expected result words
  spin_req_t req_pending_q[$];
  spin_res_t result_exp_q[$];
  int        err_cnt;

  // ---- lattice model ------------------------------------------------------
  bit          lat_spin [wcf_pkg::NSITES];
  int          lat_sum;
  logic [31:0] lat_rng;
  logic [31:0] lat_thr;
  logic [wcf_pkg::ENT_BITS-1:0] walk_stack [wcf_pkg::NSITES];

  function automatic logic [31:0] rng_advance();
    logic [31:0] x;
    x = lat_rng;
    x = x ^ (x << 13);
    x = x ^ (x >> 17);
    x = x ^ (x << 5);
    lat_rng = x;
    return x;
  endfunction

  function automatic void lat_flip(input int s);
    if (lat_spin[s]) lat_sum -= 2;
    else lat_sum += 2;
    lat_spin[s] = ~lat_spin[s];
  endfunction

  // periodic neighbor: up, down, left, right
  function automatic int lat_nbr(input int s, input logic [1:0] dir);
    int row;
    int col;
    row = s / wcf_pkg::SIDE;
    col = s % wcf_pkg::SIDE;
    case (dir)
      wcf_pkg::DIR_UP:   row = (row + wcf_pkg::SIDE - 1) % wcf_pkg::SIDE;
      wcf_pkg::DIR_DOWN: row = (row + 1) % wcf_pkg::SIDE;
      wcf_pkg::DIR_LEFT: col = (col + wcf_pkg::SIDE - 1) % wcf_pkg::SIDE;
      default:           col = (col + 1) % wcf_pkg::SIDE;
    endcase
    return row * wcf_pkg::SIDE + col;
  endfunction

  // depth-first cluster growth, flipping each site as it joins
  function automatic int flood_cluster();
    int seed;
    bit sign;
    int cnt;
    int sp;
    int s;
    int nb;
    logic [wcf_pkg::ENT_BITS-1:0] top;
    seed = int'(rng_advance() % wcf_pkg::NSITES);
    sign = lat_spin[seed];
    cnt = 1;
    lat_flip(seed);
    sp = 0;
    walk_stack[sp] = {seed[wcf_pkg::SITE_BITS-1:0], wcf_pkg::DIR_UP};
    sp++;
    while (sp > 0) begin
      top = walk_stack[sp-1];
      s = int'(top[wcf_pkg::ENT_BITS-1:2]);
      nb = lat_nbr(s, top[1:0]);
      if (top[1:0] == wcf_pkg::DIR_RIGHT) sp--;
      else walk_stack[sp-1] = top + 1'b1;
      if (lat_spin[nb] == sign) begin
        if (rng_advance() < lat_thr) begin
          lat_flip(nb);
          cnt++;
          if (sp < wcf_pkg::NSITES) begin
            walk_stack[sp] = {nb[wcf_pkg::SITE_BITS-1:0], wcf_pkg::DIR_UP};
            sp++;
          end
        end
      end
    end
    return cnt;
  endfunction

  function automatic spin_res_t apply_request(input spin_req_t r);
    spin_res_t res;
    res = '0;
    case (r.req_type)
      wcf_pkg::REQ_WRITE: if (lat_spin[r.site] != r.spin_value) lat_flip(int'(r.site));
      wcf_pkg::REQ_READ:  res.read_spin = lat_spin[r.site];
      wcf_pkg::REQ_UPDATE: res.cluster_size = wcf_pkg::CNT_BITS'(flood_cluster());
      default: ;
    endcase
    res.magnetization = wcf_pkg::MAG_BITS'(lat_sum);
    return res;
  endfunction

  // ---- clock and reset ----------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
  end

  // ---- request driver: bursts with random gaps ---------------------------
  int  burst_left;
  int  gap_left;
  bit  no_gaps;

  initial begin
    in_if.valid      = 1'b0;
    in_if.req_type   = wcf_pkg::REQ_READ;
    in_if.site       = '0;
    in_if.spin_value = 1'b0;
    burst_left = 1;
    gap_left   = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!(in_if.valid && !in_if.ready)) begin
      // slot free: either the last word was taken or nothing was offered
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        in_if.valid <= 1'b0;
      end else if (req_pending_q.size() > 0) begin
        spin_req_t r;
        r = req_pending_q.pop_front();
        in_if.valid      <= 1'b1;
        in_if.req_type   <= r.req_type;
        in_if.site       <= r.site;
        in_if.spin_value <= r.spin_value;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 12);
          gap_left   <= no_gaps ? 0 : $urandom_range(0, 6);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // ---- result receiver: stall pattern of its own ------------------------
  logic [31:0] stall_pat;
  int          stall_phase;

  initial begin
    out_if.ready = 1'b0;
    stall_pat    = '1;
    stall_phase  = 0;
  end

  always @(posedge clk) begin
    stall_phase <= stall_phase + 1;
    if (stall_phase % 32 == 31) begin
      // about one window in four, picked at random, runs without stalls
      stall_pat <= ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFFF : $urandom;
    end
    out_if.ready <= rst_n && stall_pat[stall_phase % 32];
  end

  // ---- prediction on accept, config mirror ------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (lat_spin[i]) lat_spin[i] = 1'b1;
      lat_sum = wcf_pkg::NSITES;
      lat_rng = wcf_pkg::RNG_RESET;
      lat_thr = wcf_pkg::THR_RESET;
    end else begin
      if (cfg_we) begin
        if (cfg_index == wcf_pkg::CFG_THRESHOLD) lat_thr = cfg_data;
        else lat_rng = (cfg_data == 0) ? 32'd1 : cfg_data;  // zero seed loads 1
      end
      if (in_if.valid && in_if.ready) begin
        spin_req_t r;
        r.req_type   = in_if.req_type;
        r.site       = in_if.site;
        r.spin_value = in_if.spin_value;
        result_exp_q.push_back(apply_request(r));
      end
    end
  end

  // ---- result checker ---------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (result_exp_q.size() == 0) begin
        $display("%0t: unexpected result word rd=%0d size=%0d mag=%0d", $time,
                 out_if.read_spin, out_if.cluster_size, out_if.magnetization);
        err_cnt++;
      end else begin
        spin_res_t e;
        e = result_exp_q.pop_front();
        if (out_if.read_spin !== e.read_spin) begin
          $display("%0t: read_spin exp %0d got %0d", $time, e.read_spin,
                   out_if.read_spin);
          err_cnt++;
        end
        if (out_if.cluster_size !== e.cluster_size) begin
          $display("%0t: cluster_size exp %0d got %0d", $time, e.cluster_size,
                   out_if.cluster_size);
          err_cnt++;
        end
        if (out_if.magnetization !== e.magnetization) begin
          $display("%0t: magnetization exp %0d got %0d", $time, e.magnetization,
                   out_if.magnetization);
          err_cnt++;
        end
      end
    end
  end

  // ---- watchdog: cycles without any accepted word or config write -------
  int idle_cycles;
  initial idle_cycles = 0;

  always @(posedge clk) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || cfg_we)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // ---- stimulus ---------------------------------------------------------
  task automatic cfg_write(input logic idx, input logic [31:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // block idle: nothing queued, nothing offered, nothing outstanding
  task automatic drain();
    while (req_pending_q.size() > 0 || in_if.valid || result_exp_q.size() > 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic push_req(input logic [1:0] t, input int s, input bit v);
    spin_req_t r;
    r.req_type   = t;
    r.site       = wcf_pkg::SITE_BITS'(s);
    r.spin_value = v;
    req_pending_q.push_back(r);
  endtask

  // random word: mostly updates, reads and writes, some unused codes
  task automatic push_random(input int n);
    int k;
    int s;
    logic [1:0] t;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(0, 99);
      if (k < 35) t = wcf_pkg::REQ_UPDATE;
      else if (k < 65) t = wcf_pkg::REQ_WRITE;
      else if (k < 92) t = wcf_pkg::REQ_READ;
      else t = REQ_UNUSED;
      // corners and edges now and then, to hit the wraparound
      case ($urandom_range(0, 7))
        0: s = 0;
        1: s = wcf_pkg::NSITES - 1;
        2: s = $urandom_range(0, wcf_pkg::SIDE - 1);
        3: s = $urandom_range(0, wcf_pkg::SIDE - 1) * wcf_pkg::SIDE + wcf_pkg::SIDE - 1;
        default: s = $urandom_range(0, wcf_pkg::NSITES - 1);
      endcase
      push_req(t, s, $urandom_range(0, 1));
    end
  endtask

  initial begin
    err_cnt   = 0;
    no_gaps   = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = wcf_pkg::CFG_THRESHOLD;
    cfg_data  = '0;
    @(posedge clk iff rst_n);

    // defaults: field extremes, every request code
    push_req(wcf_pkg::REQ_READ, 0, 0);
    push_req(wcf_pkg::REQ_READ, wcf_pkg::NSITES - 1, 1);
    push_req(wcf_pkg::REQ_WRITE, 0, 0);
    push_req(wcf_pkg::REQ_WRITE, wcf_pkg::NSITES - 1, 0);
    push_req(wcf_pkg::REQ_WRITE, wcf_pkg::NSITES - 1, 0);   // same value, no change
    push_req(wcf_pkg::REQ_READ, 0, 0);
    push_req(wcf_pkg::REQ_READ, wcf_pkg::NSITES - 1, 0);
    push_req(wcf_pkg::REQ_WRITE, 0, 1);
    push_req(REQ_UNUSED, wcf_pkg::NSITES - 1, 1);
    push_req(wcf_pkg::REQ_UPDATE, 0, 0);
    push_req(wcf_pkg::REQ_UPDATE, wcf_pkg::NSITES - 1, 1);
    push_req(wcf_pkg::REQ_UPDATE, 0, 0);
    drain();

    // zero threshold: only the seed flips; zero seed must load as one
    cfg_write(wcf_pkg::CFG_THRESHOLD, 32'd0);
    cfg_write(wcf_pkg::CFG_SEED, 32'd0);
    repeat (4) push_req(wcf_pkg::REQ_UPDATE, 0, 0);
    push_req(wcf_pkg::REQ_READ, 5, 0);
    drain();

    // full threshold: the cluster floods the whole same-sign region once
    cfg_write(wcf_pkg::CFG_THRESHOLD, 32'hFFFF_FFFF);
    cfg_write(wcf_pkg::CFG_SEED, 32'hFFFF_FFFF);
    push_req(wcf_pkg::REQ_UPDATE, 0, 0);
    push_req(wcf_pkg::REQ_READ, 1, 0);
    push_req(REQ_UNUSED, 0, 0);
    drain();

    // random phases with assorted settings, some near the critical bond
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: cfg_write(wcf_pkg::CFG_THRESHOLD, wcf_pkg::THR_RESET);
        1: cfg_write(wcf_pkg::CFG_THRESHOLD, 32'd2_400_000_000);
        2: cfg_write(wcf_pkg::CFG_THRESHOLD, 32'd1);
        default: cfg_write(wcf_pkg::CFG_THRESHOLD, $urandom_range(0, 32'd2_200_000_000));
      endcase
      cfg_write(wcf_pkg::CFG_SEED, $urandom);
      no_gaps = (ph == 3);
      push_random(ph == 1 ? 100 : 200);
      drain();
    end

    repeat (50) @(posedge clk);
    if (err_cnt == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
